// ----- hdl/double_click_detector_defines.svh -----
// assertion macros for the double click detector checker
// depends on nothing; the asserting file provides clk and rst_n
`ifndef DOUBLE_CLICK_DETECTOR_DEFINES_SVH
`define DOUBLE_CLICK_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define DCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dcd_pkg.sv -----
// shared types and constants of the double click detector
// used by dcd_core and double_click_detector; no dependencies
package dcd_pkg;

  localparam int unsigned CntW     = 16;
  localparam int unsigned CfgAddrW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  localparam logic [CntW-1:0] MinPressRst = 16'd3;
  localparam logic [CntW-1:0] MaxPressRst = 16'd50;
  localparam logic [CntW-1:0] GapLimitRst = 16'd30;
  localparam logic [CntW-1:0] PressCapRst = 16'd60000;
  localparam logic [CntW-1:0] GapTop      = 16'hFFFF;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_MIN_PRESS = 8'd0,
    CFG_MAX_PRESS = 8'd1,
    CFG_GAP_LIMIT = 8'd2,
    CFG_PRESS_CAP = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CntW-1:0] press_cap;
    logic [CntW-1:0] gap_limit;
    logic [CntW-1:0] max_press;
    logic [CntW-1:0] min_press;
  } cfg_regs_t;

  // bit 0 double_seen, bit 1 led_on
  typedef struct packed {
    logic led_on;
    logic double_seen;
  } dcd_result_t;

endpackage

// ----- hdl/double_click_detector.sv -----
// double click detector: an accepted beat's result is registered in the output register
// or skid; one beat per clock while in_tready is high, set by the single state update
// a two-entry output (result register plus skid) keeps in_tready high while one result
// waits; in_tready drops only when both entries are full
// reset (rst_n low, synchronous) clears counters, flags, led level and both output
// entries, and loads the registers with min 3, max 50, gap 30, cap 60000
// depends on dcd_pkg and dcd_core
module double_click_detector import dcd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [0] pressed, [7:1] zero
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [0] double_seen, [1] led_on, [7:2] zero
  // configuration writes
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_regs_t   cfg_r;
  dcd_result_t step_res;
  dcd_result_t out_res_r;
  dcd_result_t skid_res_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  logic        in_beat;
  logic        out_beat;

  // register writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_press <= MinPressRst;
      cfg_r.max_press <= MaxPressRst;
      cfg_r.gap_limit <= GapLimitRst;
      cfg_r.press_cap <= PressCapRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MIN_PRESS: cfg_r.min_press <= cfg_wdata;
        CFG_MAX_PRESS: cfg_r.max_press <= cfg_wdata;
        CFG_GAP_LIMIT: cfg_r.gap_limit <= cfg_wdata;
        CFG_PRESS_CAP: cfg_r.press_cap <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ready only depends on the skid entry, so in_tready has no path from out_tready
  assign in_tready = ~skid_valid_r;
  assign in_beat   = in_tvalid & in_tready;
  assign out_beat  = out_tvalid & out_tready;

  // state update happens on the accepted beat; result is the post-update state
  dcd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_beat),
    .pressed (in_tdata[0]),
    .cfg     (cfg_r),
    .result  (step_res)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_beat) begin
      // skid is empty here
      if (!out_valid_r || out_beat) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_beat) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat) begin
      if (!out_valid_r || out_beat) begin
        out_res_r <= step_res;
      end else begin
        skid_res_r <= step_res;
      end
    end else if (out_beat && skid_valid_r) begin
      out_res_r <= skid_res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-2){1'b0}}, out_res_r.led_on, out_res_r.double_seen};

endmodule

// ----- hdl/dcd_core.sv -----
// press / gap counters and detection state of the double click detector
// depends on dcd_pkg
module dcd_core import dcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        pressed,
  input  cfg_regs_t   cfg,
  output dcd_result_t result
);

  logic [CntW-1:0] press_ticks_r, press_ticks_nxt;
  logic [CntW-1:0] gap_ticks_r, gap_ticks_nxt;
  logic [CntW-1:0] gap_inc;
  logic            holding_r, holding_nxt;
  logic            pending_r, pending_nxt;
  logic            detected_r, detected_nxt;
  logic            acted_r, acted_nxt;
  logic            led_r, led_nxt;

  assign gap_inc = (gap_ticks_r != GapTop) ? gap_ticks_r + 16'd1 : gap_ticks_r;

  always_comb begin
    press_ticks_nxt = press_ticks_r;
    gap_ticks_nxt   = gap_ticks_r;
    holding_nxt     = holding_r;
    pending_nxt     = pending_r;
    detected_nxt    = detected_r;
    acted_nxt       = acted_r;
    led_nxt         = led_r;

    if (pressed) begin
      if (!holding_r) begin
        detected_nxt = 1'b0;
      end
      holding_nxt   = 1'b1;
      gap_ticks_nxt = '0;
      if (press_ticks_r < cfg.press_cap) begin
        press_ticks_nxt = press_ticks_r + 16'd1;
      end
    end else if (holding_r) begin
      holding_nxt = 1'b0;
      if (press_ticks_r > cfg.min_press && press_ticks_r < cfg.max_press) begin
        // second valid click completes a double
        if (pending_r) begin
          detected_nxt = 1'b1;
          pending_nxt  = 1'b0;
        end else begin
          pending_nxt = 1'b1;
        end
      end else begin
        pending_nxt = 1'b0;
      end
      press_ticks_nxt = '0;
    end else if (pending_r) begin
      if (gap_inc > cfg.gap_limit) begin
        pending_nxt   = 1'b0;
        gap_ticks_nxt = '0;
      end else begin
        gap_ticks_nxt = gap_inc;
      end
    end

    // one toggle per detection
    if (detected_nxt) begin
      if (!acted_r) begin
        led_nxt   = ~led_r;
        acted_nxt = 1'b1;
      end
    end else begin
      acted_nxt = 1'b0;
    end
  end

  assign result.double_seen = detected_nxt;
  assign result.led_on      = led_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r <= '0;
      gap_ticks_r   <= '0;
      holding_r     <= 1'b0;
      pending_r     <= 1'b0;
      detected_r    <= 1'b0;
      acted_r       <= 1'b0;
      led_r         <= 1'b0;
    end else if (step) begin
      press_ticks_r <= press_ticks_nxt;
      gap_ticks_r   <= gap_ticks_nxt;
      holding_r     <= holding_nxt;
      pending_r     <= pending_nxt;
      detected_r    <= detected_nxt;
      acted_r       <= acted_nxt;
      led_r         <= led_nxt;
    end
  end

endmodule

// ----- hdl/dcd_checker.sv -----
// port-level checks for the double click detector, bound to the top level
// depends on dcd_pkg and double_click_detector_defines.svh
`include "double_click_detector_defines.svh"

module dcd_checker import dcd_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  logic have_prev_r;
  logic prev_double_r;
  logic prev_led_r;
  logic out_beat;
  logic led_flip;
  logic double_rise;

  assign out_beat    = out_tvalid & out_tready;
  assign led_flip    = out_tdata[1] != prev_led_r;
  assign double_rise = out_tdata[0] & ~prev_double_r;

  // last delivered result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r   <= 1'b0;
      prev_double_r <= 1'b0;
      prev_led_r    <= 1'b0;
    end else if (out_beat) begin
      have_prev_r   <= 1'b1;
      prev_double_r <= out_tdata[0];
      prev_led_r    <= out_tdata[1];
    end
  end

  `DCD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result beat changed")
  `DCD_ASSERT_NOW(a_led_once, out_beat && have_prev_r, led_flip == double_rise, "led toggle does not match a new detection")
  `DCD_ASSERT_NOW(a_stall_full, !in_tready, out_tvalid, "input stalled with no result waiting")

endmodule

bind double_click_detector dcd_checker u_dcd_checker (.*);

// ----- sim/tb.sv -----
// self-checking bench for double_click_detector: button level beats in, flag and led level out
// carries its own click tracker class that predicts every result beat and scores the outputs
// depends on dcd_pkg and the double_click_detector rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcd_pkg::*;

  // register indexes at and above this one are not implemented and must be ignored
  localparam int unsigned FirstSpareIdx = int'(CFG_PRESS_CAP) + 1;
  localparam int unsigned LastIdx       = (1 << CfgAddrW) - 1;
  // cycles without any accepted beat before the run is declared hung
  localparam int unsigned StallLimit    = 5000;
  // one long receiver hold-off, long enough to fill the output skid and stall the input
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned RandomBeats   = 980;
  localparam int unsigned MaxReports    = 10;

  // ---------------------------------------------------------------------------------------
  // click tracker: mirrors the detector state and holds the results still owed by the dut
  // ---------------------------------------------------------------------------------------
  class click_tracker;
    cfg_regs_t       cfg;
    logic [CntW-1:0] press_len;
    logic [CntW-1:0] gap_len;
    bit              was_down;
    logic [1:0]      click_cnt;
    bit              flag_held;
    bit              toggled;
    bit              led;
    dcd_result_t     owed_q[$];
    int unsigned     failures;
    int unsigned     checked;
    int unsigned     doubles;

    function new();
      cfg.min_press = MinPressRst;
      cfg.max_press = MaxPressRst;
      cfg.gap_limit = GapLimitRst;
      cfg.press_cap = PressCapRst;
      press_len = '0;
      gap_len   = '0;
      was_down  = 1'b0;
      click_cnt = '0;
      flag_held = 1'b0;
      toggled   = 1'b0;
      led       = 1'b0;
      failures  = 0;
      checked   = 0;
      doubles   = 0;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_MIN_PRESS: cfg.min_press = val;
        CFG_MAX_PRESS: cfg.max_press = val;
        CFG_GAP_LIMIT: cfg.gap_limit = val;
        CFG_PRESS_CAP: cfg.press_cap = val;
        default: ;  // unimplemented index, dropped
      endcase
    endfunction

    // one sampled button level in, one expected result beat queued
    function void note_input(bit down);
      dcd_result_t res;
      if (down) begin
        if (!was_down) flag_held = 1'b0;
        was_down = 1'b1;
        gap_len  = '0;
        // counter only stops at the cap, it never drops when the cap is lowered
        if (press_len < cfg.press_cap) press_len = press_len + 1'b1;
      end else if (was_down) begin
        was_down = 1'b0;
        if (press_len > cfg.min_press && press_len < cfg.max_press) begin
          click_cnt = click_cnt + 2'd1;
          if (click_cnt == 2'd2) begin
            flag_held = 1'b1;
            click_cnt = '0;
          end
        end else begin
          click_cnt = '0;
        end
        press_len = '0;
      end else if (click_cnt != 2'd0) begin
        // gap counter saturates, so the largest gap limit never cancels
        if (gap_len < GapTop) gap_len = gap_len + 1'b1;
        if (gap_len > cfg.gap_limit) begin
          click_cnt = '0;
          gap_len   = '0;
        end
      end
      if (flag_held) begin
        if (!toggled) begin
          led     = !led;
          toggled = 1'b1;
          doubles++;
        end
      end else begin
        toggled = 1'b0;
      end
      res.double_seen = flag_held;
      res.led_on      = led;
      owed_q.push_back(res);
    endfunction

    function void report(string what, logic [OutDataW-1:0] got, logic [OutDataW-1:0] want);
      failures++;
      if (failures <= MaxReports)
        $display("%t mismatch on result %0d: %s, got %b want %b",
                 $realtime, checked, what, got, want);
    endfunction

    function void check_result(logic [OutDataW-1:0] beat);
      dcd_result_t want;
      checked++;
      if (owed_q.size() == 0) begin
        report("result beat with nothing owed", beat, '0);
        return;
      end
      want = owed_q.pop_front();
      if (beat[0] !== want.double_seen)
        report("double_seen", OutDataW'(beat[0]), OutDataW'(want.double_seen));
      if (beat[1] !== want.led_on)
        report("led_on", OutDataW'(beat[1]), OutDataW'(want.led_on));
      if (beat[OutDataW-1:2] !== '0)
        report("padding bits", beat, OutDataW'({want.led_on, want.double_seen}));
    endfunction

    function int unsigned owed();
      return owed_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------------------
  // clock, reset and dut
  // ---------------------------------------------------------------------------------------
  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;   // [0] pressed, [7:1] zero
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;         // [0] double_seen, [1] led_on, [7:2] zero
  logic                cfg_we     = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr   = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;

  always #4 clk = ~clk;

  double_click_detector i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  click_tracker tracker = new();

  int unsigned beats_in       = 0;
  int unsigned regs_written   = 0;
  int unsigned idle_run       = 0;
  bit          tx_calm        = 1'b0;  // sender stretch with no gaps
  bit          rx_calm        = 1'b0;  // receiver stretch with no gaps
  bit          fast_mode      = 1'b0;  // both sides idle-free, for the long gap sequence
  bit          hold_off_req   = 1'b0;
  bit          hold_off_done  = 1'b0;

  // gap length: mostly none or short, now and then a long one
  function automatic int pick_gap(bit calm);
    int r;
    if (calm || fast_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------------------
  // result side: sample at the rising edge, ready driven at the falling edge
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  initial begin
    int idle;
    int busy;
    wait (rst_n);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        // long hold-off: the sender keeps offering, so the skid fills and in_tready drops
        hold_off_done = 1'b1;
        @(negedge clk) out_tready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk);
      end
      idle = pick_gap(rx_calm);
      if (idle > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (idle - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
      busy = fast_mode ? 0 : $urandom_range(0, 7);
      repeat (busy) @(negedge clk);
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
    end
  end

  // watchdog: any accepted beat on either side resets the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_run <= 0;
    end else if (idle_run >= StallLimit) begin
      $display("%t no beat moved for %0d cycles, %0d results still owed",
               $realtime, StallLimit, tracker.owed());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // input side tasks
  // ---------------------------------------------------------------------------------------
  task automatic send_beat(input bit down);
    int idle;
    idle = pick_gap(tx_calm);
    if (idle > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW-1){1'b0}}, down};
    // in_tready read at the edge, before the dut's registers move
    do @(posedge clk); while (!in_tready);
    tracker.note_input(down);
    beats_in++;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
  endtask

  task automatic send_run(input bit down, input int n);
    repeat (n) send_beat(down);
  endtask

  task automatic press_release(input int held, input int released);
    send_run(1'b1, held);
    send_run(1'b0, released);
  endtask

  // wait until every owed result is back, with the input idle
  task automatic settle();
    @(negedge clk) in_tvalid <= 1'b0;
    while (tracker.owed() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tracker.write_reg(idx, val);
    regs_written++;
  endtask

  task automatic apply_setting(input logic [CntW-1:0] mn, input logic [CntW-1:0] mx,
                               input logic [CntW-1:0] gl, input logic [CntW-1:0] cap);
    settle();
    write_reg(CFG_MIN_PRESS, mn);
    write_reg(CFG_MAX_PRESS, mx);
    write_reg(CFG_GAP_LIMIT, gl);
    write_reg(CFG_PRESS_CAP, cap);
  endtask

  // press length inside the click window where one exists with a low edge of 40 or less, kept short
  function automatic int click_len();
    int lo;
    int hi;
    lo = int'(tracker.cfg.min_press) + 1;
    hi = int'(tracker.cfg.max_press) - 1;
    if (hi < lo || lo > 40) return $urandom_range(1, 8);
    if (hi > lo + 10) hi = lo + 10;
    return $urandom_range(lo, hi);
  endfunction

  task automatic random_setting();
    logic [CntW-1:0] mn;
    logic [CntW-1:0] mx;
    logic [CntW-1:0] gl;
    logic [CntW-1:0] cap;
    if ($urandom_range(0, 7) == 0) begin
      // full-range values, mostly an empty or unreachable window
      mn  = 16'($urandom());
      mx  = 16'($urandom());
      gl  = 16'($urandom());
      cap = 16'($urandom());
    end else begin
      // narrow windows so short presses hit both edges; offset 0 or 1 gives an empty window
      mn  = 16'($urandom_range(0, 6));
      mx  = mn + 16'($urandom_range(0, 10));
      gl  = 16'($urandom_range(0, 12));
      cap = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 12)) : GapTop;
    end
    apply_setting(mn, mx, gl, cap);
    if ($urandom_range(0, 3) == 0)
      write_reg(CfgAddrW'($urandom_range(FirstSpareIdx, LastIdx)), 16'($urandom()));
  endtask

  // mostly clean click pairs with random lengths and gaps, the rest edge presses and noise
  task automatic random_phase(input int target);
    int done_here;
    int r;
    int len;
    int gap;
    int top;
    int gl;
    done_here = 0;
    gl = int'(tracker.cfg.gap_limit);
    while (done_here < target) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        repeat ($urandom_range(2, 3)) begin
          len = click_len();
          top = (gl > 14) ? 15 : gl + 1;
          gap = $urandom_range(1, top);
          // one released tick too many cancels the pending click
          if ($urandom_range(0, 7) == 0 && gl < 40) gap = gl + 2;
          press_release(len, gap);
          done_here += len + gap;
        end
      end else if (r == 7) begin
        case ($urandom_range(0, 3))
          0: len = int'(tracker.cfg.min_press);
          1: len = int'(tracker.cfg.max_press);
          2: len = int'(tracker.cfg.min_press) + 1;
          default: len = int'(tracker.cfg.max_press) - 1;
        endcase
        if (len < 1) len = 1;
        if (len > 40) len = 40;
        gap = $urandom_range(1, 4);
        press_release(len, gap);
        done_here += len + gap;
      end else begin
        len = $urandom_range(1, 12);
        repeat (len) send_beat(1'($urandom_range(0, 1)));
        done_here += len;
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    int unsigned random_start;
    int phase_no;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset values: two clean clicks make a double, the led toggles
    press_release(4, 1);
    press_release(4, 2);
    // the next press drops the flag; a press of exactly min_press is no click
    press_release(1, 1);
    press_release(3, 1);

    // widest window, zero gap, cap zero keeps the press counter at zero
    apply_setting(16'd0, GapTop, 16'd0, 16'd0);
    press_release(2, 1);
    // one-tick clicks back to back; then a single released tick past a zero gap limit
    apply_setting(16'd0, 16'd2, 16'd0, GapTop);
    press_release(1, 1);
    press_release(1, 2);
    press_release(1, 1);

    // cap lowered below a running press count: the count holds, the press still counts
    apply_setting(16'd3, 16'd10, 16'd5, 16'd8);
    send_run(1'b1, 6);
    settle();
    write_reg(CFG_PRESS_CAP, 16'd2);
    write_reg(CfgAddrW'(FirstSpareIdx), GapTop);  // ignored index
    write_reg(CfgAddrW'(LastIdx), 16'd0);
    send_run(1'b1, 3);
    send_run(1'b0, 1);

    // empty window at the opposite extremes
    apply_setting(GapTop, 16'd0, GapTop, GapTop);
    press_release(2, 1);

    // random part, one phase per register setting
    random_start = beats_in;
    phase_no = 0;
    while (beats_in - random_start < RandomBeats) begin
      random_setting();
      if (phase_no == 2) begin
        hold_off_req = 1'b1;
        random_phase(150);
      end else begin
        random_phase($urandom_range(60, 120));
      end
      phase_no++;
    end

    // largest gap limit: a long released stretch keeps the first click pending
    apply_setting(16'd3, 16'd50, GapTop, GapTop);
    fast_mode = 1'b1;
    press_release(4, 120);
    press_release(4, 1);
    fast_mode = 1'b0;

    settle();
    repeat (8) @(negedge clk);

    $display("covered %0d button beats across %0d register writes, incl. a long pending gap",
             beats_in, regs_written);
    $display("checked %0d result beats, %0d double clicks, one %0d-cycle receiver hold-off",
             tracker.checked, tracker.doubles, HoldOffCycles);
    if (tracker.failures == 0 && tracker.owed() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", tracker.failures);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
